>>> rtl/core/bfr_pkg.sv
// Shared types and constants of the MSB-first bit field reader.
`timescale 1ns / 1ps
`default_nettype none
package bfr_pkg;

   localparam int BUF_BYTES      = 2048;
   localparam int ADDR_W         = $clog2(BUF_BYTES);
   localparam int COUNT_W        = 15;
   localparam int MAX_FIELD_BITS = 32;
   localparam int FIELD_W        = 32;
   localparam int FCNT_W         = $clog2(MAX_FIELD_BITS + 1);
   // Worst case a field starting at bit 0 touches this many bytes.
   localparam int WIN_BYTES      = (MAX_FIELD_BITS + 7 + 7) / 8;
   localparam int WIN_W          = 8 * WIN_BYTES;
   localparam int SLOT_W         = $clog2(WIN_BYTES);
   localparam int SHAMT_W        = $clog2(WIN_W + 1) + 1;

   localparam int CSR_ADDR_W     = 4;
   localparam int CSR_DATA_W     = 32;

   localparam logic [1:0] REG_START_OFFSET = 2'd0;
   localparam logic [1:0] REG_START_BIT    = 2'd1;
   localparam logic [1:0] REG_TOTAL_BITS   = 2'd2;

   typedef enum logic [2:0] {
      ACT_WRITE  = 3'd0,
      ACT_READ   = 3'd1,
      ACT_PEEK   = 3'd2,
      ACT_SKIP   = 3'd3,
      ACT_REWIND = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_WAIT,
      ST_SHIFT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  start_offset;
      logic [2:0]         start_bit;
      logic [COUNT_W-1:0] total_bits;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  byte_pos;
      logic [2:0]         bit_pos;
      logic [COUNT_W-1:0] bits_left;
   } cursor_type;

   typedef struct packed {
      logic ok;
      logic fetch;
   } decision_type;

   typedef struct packed {
      logic start;
      logic issue;
   } fetch_ctl_type;

   typedef struct packed {
      logic              last_issue;
      logic              busy;
      logic [SLOT_W-1:0] slot;
   } fetch_stat_type;

endpackage
`default_nettype wire

>>> rtl/core/bfr_store.sv
// Byte store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bfr_store (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [bfr_pkg::ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]                wr_data,
   input  wire logic                      rd_en,
   input  wire logic [bfr_pkg::ADDR_W-1:0] rd_addr,
   output logic      [7:0]                rd_data
);

   logic [7:0] mem [bfr_pkg::BUF_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/core/bfr_cursor.sv
// Read cursor registers and the accept/refuse decision for each action.
`timescale 1ns / 1ps
`default_nettype none
module bfr_cursor (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [2:0]                  action,
   input  wire logic [bfr_pkg::COUNT_W-1:0] count,
   input  wire bfr_pkg::cfg_type            cfg,
   output bfr_pkg::cursor_type              cursor,
   output bfr_pkg::decision_type            decision
);

   bfr_pkg::cursor_type cursor_ff;
   bfr_pkg::cursor_type cursor_in;
   bfr_pkg::cursor_type advanced;
   logic [bfr_pkg::COUNT_W:0] span;
   logic fits;
   logic narrow;

   // Bits consumed from the current byte onward; the byte step is span / 8.
   assign span = {{(bfr_pkg::COUNT_W - 2){1'b0}}, ~cursor_ff.bit_pos} + {1'b0, count};
   assign advanced.byte_pos  = cursor_ff.byte_pos + span[bfr_pkg::ADDR_W+2:3];
   assign advanced.bit_pos   = ~span[2:0];
   assign advanced.bits_left = cursor_ff.bits_left - count;

   assign fits   = count <= cursor_ff.bits_left;
   assign narrow = count <= bfr_pkg::COUNT_W'(bfr_pkg::MAX_FIELD_BITS);

   always_comb begin
      cursor_in      = cursor_ff;
      decision.ok    = 1'b0;
      decision.fetch = 1'b0;
      unique case (action)
         bfr_pkg::ACT_WRITE: begin
            decision.ok = 1'b1;
         end
         bfr_pkg::ACT_READ: begin
            decision.ok    = fits && narrow;
            decision.fetch = fits && narrow && (count != '0);
            if (fits && narrow) begin
               cursor_in = advanced;
            end
         end
         bfr_pkg::ACT_PEEK: begin
            decision.ok    = fits && narrow;
            decision.fetch = fits && narrow && (count != '0);
         end
         bfr_pkg::ACT_SKIP: begin
            decision.ok = fits;
            if (fits) begin
               cursor_in = advanced;
            end
         end
         bfr_pkg::ACT_REWIND: begin
            decision.ok         = 1'b1;
            cursor_in.byte_pos  = cfg.start_offset;
            cursor_in.bit_pos   = cfg.start_bit;
            cursor_in.bits_left = cfg.total_bits;
         end
         default: begin
            decision.ok = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff.byte_pos  <= '0;
         cursor_ff.bit_pos   <= 3'd7;
         cursor_ff.bits_left <= '0;
      end else if (accept) begin
         cursor_ff <= cursor_in;
      end
   end

   assign cursor = cursor_ff;

endmodule
`default_nettype wire

>>> rtl/core/bfr_fetch.sv
// Byte fetch sequencer, field window and the aligning shifter.
`timescale 1ns / 1ps
`default_nettype none
module bfr_fetch (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bfr_pkg::fetch_ctl_type      ctl,
   input  wire logic [bfr_pkg::ADDR_W-1:0]  base_pos,
   input  wire logic [2:0]                  bit_pos,
   input  wire logic [bfr_pkg::FCNT_W-1:0]  count,
   input  wire logic [7:0]                  mem_rdata,
   output logic                             mem_rd,
   output logic      [bfr_pkg::ADDR_W-1:0]  mem_raddr,
   output bfr_pkg::fetch_stat_type          stat,
   output logic      [bfr_pkg::FIELD_W-1:0] field
);

   localparam int SPAN_W = bfr_pkg::FCNT_W + 1;

   logic [bfr_pkg::ADDR_W-1:0]  base_ff;
   logic [2:0]                  bit_ff;
   logic [bfr_pkg::FCNT_W-1:0]  cnt_ff;
   logic [bfr_pkg::SLOT_W-1:0]  last_ff;
   logic [bfr_pkg::SLOT_W-1:0]  last_in;
   logic [bfr_pkg::SLOT_W-1:0]  slot_ff;
   logic                        rd_pend_ff;
   logic [bfr_pkg::SLOT_W-1:0]  rd_slot_ff;
   logic [7:0]                  win_ff [bfr_pkg::WIN_BYTES];
   logic [SPAN_W-1:0]           span_m1;
   logic [bfr_pkg::WIN_W-1:0]   window;
   logic [bfr_pkg::WIN_W-1:0]   shifted;
   logic [bfr_pkg::SHAMT_W-1:0] shamt;
   logic [bfr_pkg::FIELD_W:0]   mask;

   // Index of the last byte the field touches, counted from its first byte.
   assign span_m1 = {{(SPAN_W - 3){1'b0}}, ~bit_pos} + {1'b0, count} - SPAN_W'(1);
   assign last_in = span_m1[bfr_pkg::SLOT_W+2:3];

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         base_ff <= base_pos;
         bit_ff  <= bit_pos;
         cnt_ff  <= count;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= ctl.issue;
         if (ctl.start) begin
            slot_ff <= '0;
         end else if (ctl.issue) begin
            slot_ff <= slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.issue) begin
         rd_slot_ff <= slot_ff;
      end
   end

   // Bytes beyond the field are cleared so the shifter never sees stale data.
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         for (int k = 0; k < bfr_pkg::WIN_BYTES; k++) begin
            win_ff[k] <= '0;
         end
      end else if (rd_pend_ff) begin
         win_ff[rd_slot_ff] <= mem_rdata;
      end
   end

   assign mem_rd    = ctl.issue;
   assign mem_raddr = base_ff + {{(bfr_pkg::ADDR_W - bfr_pkg::SLOT_W){1'b0}}, slot_ff};

   always_comb begin
      for (int k = 0; k < bfr_pkg::WIN_BYTES; k++) begin
         window[bfr_pkg::WIN_W-1-8*k -: 8] = win_ff[k];
      end
   end

   // The first field bit sits at window bit 32 + bit; its last bit lands on bit 0.
   assign shamt   = bfr_pkg::SHAMT_W'(bfr_pkg::WIN_W - 7) + {{(bfr_pkg::SHAMT_W - 3){1'b0}}, bit_ff}
                    - {{(bfr_pkg::SHAMT_W - bfr_pkg::FCNT_W){1'b0}}, cnt_ff};
   assign shifted = window >> shamt;
   assign mask    = ({{bfr_pkg::FIELD_W{1'b0}}, 1'b1} << cnt_ff) - 1'b1;
   assign field   = shifted[bfr_pkg::FIELD_W-1:0] & mask[bfr_pkg::FIELD_W-1:0];

   assign stat.last_issue = (slot_ff == last_ff);
   assign stat.busy       = rd_pend_ff;
   assign stat.slot       = slot_ff;

endmodule
`default_nettype wire

>>> rtl/core/msb_first_bit_field_reader.sv
// Top level of the MSB-first bit field reader: control, registers and result beat.
//
// The reader walks a 2048-byte store with a cursor and returns one result beat per
// request beat. Write, skip, rewind, refused actions and zero-bit reads go straight
// to the result state; a read or peek of 1 to 32 bits first fetches the 1 to 5 store
// bytes the field touches, one byte per cycle from the single store read port, then
// aligns the field. One request is worked on at a time; a new request is taken while
// the previous result beat still waits on rsp_ready. The store has no reset: bytes
// must be written before a field covers them. The user is to write registers through
// the APB port only while no request is outstanding; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module msb_first_bit_field_reader (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [2:0]                        req_action,
   input  wire logic [bfr_pkg::COUNT_W-1:0]       req_bit_count,
   input  wire logic [10:0]                       req_byte_addr,
   input  wire logic [7:0]                        req_byte_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_ok,
   output logic      [bfr_pkg::FIELD_W-1:0]       rsp_field_value,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [bfr_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [bfr_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [bfr_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                   pready
);

   bfr_pkg::state_type      state_ff;
   bfr_pkg::state_type      state_in;
   bfr_pkg::cfg_type        cfg_ff;
   bfr_pkg::cursor_type     cursor;
   bfr_pkg::decision_type   decision;
   bfr_pkg::fetch_ctl_type  fetch_ctl;
   bfr_pkg::fetch_stat_type fetch_stat;

   logic                         accept;
   logic                         csr_write;
   logic                         out_free;
   logic                         deliver;
   logic                         load_field;
   logic                         mem_rd;
   logic [bfr_pkg::ADDR_W-1:0]   mem_raddr;
   logic [7:0]                   mem_rdata;
   logic [bfr_pkg::FIELD_W-1:0]  field;
   logic                         res_ok_ff;
   logic [bfr_pkg::FIELD_W-1:0]  res_field_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic                         rsp_ok_ff;
   logic [bfr_pkg::FIELD_W-1:0]  rsp_field_ff;

   assign accept    = req_valid && req_ready;
   assign csr_write = psel && penable && pwrite && pready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_offset <= '0;
         cfg_ff.start_bit    <= 3'd7;
         cfg_ff.total_bits   <= '0;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            bfr_pkg::REG_START_OFFSET: cfg_ff.start_offset <= pwdata[bfr_pkg::ADDR_W-1:0];
            bfr_pkg::REG_START_BIT:    cfg_ff.start_bit    <= pwdata[2:0];
            bfr_pkg::REG_TOTAL_BITS:   cfg_ff.total_bits   <= pwdata[bfr_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         bfr_pkg::REG_START_OFFSET:
            prdata = {{(bfr_pkg::CSR_DATA_W - bfr_pkg::ADDR_W){1'b0}}, cfg_ff.start_offset};
         bfr_pkg::REG_START_BIT:
            prdata = {{(bfr_pkg::CSR_DATA_W - 3){1'b0}}, cfg_ff.start_bit};
         bfr_pkg::REG_TOTAL_BITS:
            prdata = {{(bfr_pkg::CSR_DATA_W - bfr_pkg::COUNT_W){1'b0}}, cfg_ff.total_bits};
         default:
            prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   bfr_cursor u_cursor (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .action   (req_action),
      .count    (req_bit_count),
      .cfg      (cfg_ff),
      .cursor   (cursor),
      .decision (decision)
   );

   // A write lands before any later fetch can be issued, so no forwarding is needed.
   bfr_store u_store (
      .clock   (clock),
      .wr_en   (accept && (req_action == bfr_pkg::ACT_WRITE)),
      .wr_addr (req_byte_addr[bfr_pkg::ADDR_W-1:0]),
      .wr_data (req_byte_value),
      .rd_en   (mem_rd),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   bfr_fetch u_fetch (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fetch_ctl),
      .base_pos  (cursor.byte_pos),
      .bit_pos   (cursor.bit_pos),
      .count     (req_bit_count[bfr_pkg::FCNT_W-1:0]),
      .mem_rdata (mem_rdata),
      .mem_rd    (mem_rd),
      .mem_raddr (mem_raddr),
      .stat      (fetch_stat),
      .field     (field)
   );

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfr_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = decision.fetch ? bfr_pkg::ST_FETCH : bfr_pkg::ST_RESP;
            end
         end
         bfr_pkg::ST_FETCH: begin
            if (fetch_stat.last_issue) begin
               state_in = bfr_pkg::ST_WAIT;
            end
         end
         bfr_pkg::ST_WAIT:  state_in = bfr_pkg::ST_SHIFT;
         bfr_pkg::ST_SHIFT: state_in = bfr_pkg::ST_RESP;
         bfr_pkg::ST_RESP: begin
            if (out_free) begin
               state_in = bfr_pkg::ST_IDLE;
            end
         end
         default: state_in = bfr_pkg::ST_IDLE;
      endcase
   end

   // Sequencer: outputs.
   always_comb begin
      req_ready       = (state_ff == bfr_pkg::ST_IDLE) && !reset;
      fetch_ctl.start = (state_ff == bfr_pkg::ST_IDLE) && req_valid && decision.fetch;
      fetch_ctl.issue = (state_ff == bfr_pkg::ST_FETCH);
      load_field      = (state_ff == bfr_pkg::ST_SHIFT);
      deliver         = (state_ff == bfr_pkg::ST_RESP) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Pending result while the item is worked on.
   always_ff @(posedge clock) begin
      if (accept) begin
         res_ok_ff    <= decision.ok;
         res_field_ff <= '0;
      end else if (load_field) begin
         res_field_ff <= field;
      end
   end

   // Output register for the result beat.
   assign rsp_valid_in = deliver || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (deliver) begin
         rsp_ok_ff    <= res_ok_ff;
         rsp_field_ff <= res_field_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_field_value = rsp_field_ff;

   // A refused action always carries a zero field.
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> (rsp_field_ff == '0))
      else $error("refused result carries a nonzero field");

   // The fetch never runs past the end of the field window.
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      fetch_ctl.issue |-> (fetch_stat.slot < bfr_pkg::SLOT_W'(bfr_pkg::WIN_BYTES)))
      else $error("fetch slot beyond the field window");

   // A new request is never taken while a store read is still in flight.
   a_no_accept_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |-> !fetch_stat.busy)
      else $error("request accepted during a store read");

   // A result beat enters the output register only after the previous one left it.
   a_deliver_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> !$past(deliver))
      else $error("result beat overwritten before it was taken");

endmodule
`default_nettype wire

>>> test/msb_first_bit_field_reader_tb.sv
// Self-checking testbench for the MSB-first bit field reader.
`timescale 1ns / 1ps
module msb_first_bit_field_reader_tb;

   localparam int WATCHDOG_CYCLES = 5000;
   localparam int REPORT_LINES    = 100;
   // Action codes above rewind are not decoded by the block.
   localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
   localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [31:0]                 seq;
      logic                        ok;
      logic [bfr_pkg::FIELD_W-1:0] value;
   } field_beat_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic [2:0]                       req_action;
   logic [bfr_pkg::COUNT_W-1:0]      req_bit_count;
   logic [10:0]                      req_byte_addr;
   logic [7:0]                       req_byte_value;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic                             rsp_ok;
   logic [bfr_pkg::FIELD_W-1:0]      rsp_field_value;
   logic                             psel;
   logic                             penable;
   logic                             pwrite;
   logic [bfr_pkg::CSR_ADDR_W-1:0]   paddr;
   logic [bfr_pkg::CSR_DATA_W-1:0]   pwdata;
   logic [bfr_pkg::CSR_DATA_W-1:0]   prdata;
   logic                             pready;

   // Shadow copy of the block: store, cursor and stream registers.
   logic [7:0]                       shadow_bytes [bfr_pkg::BUF_BYTES];
   bit                               byte_written [bfr_pkg::BUF_BYTES];
   logic [bfr_pkg::ADDR_W-1:0]       cur_pos  = '0;
   logic [2:0]                       cur_bit  = 3'd7;
   logic [bfr_pkg::COUNT_W-1:0]      cur_left = '0;
   logic [bfr_pkg::ADDR_W-1:0]       cfg_offset = '0;
   logic [2:0]                       cfg_bit    = 3'd7;
   logic [bfr_pkg::COUNT_W-1:0]      cfg_total  = '0;

   field_beat_type          expected_beats [$];
   field_beat_type          head;
   int                      seq_no = 0;
   int                      error_count = 0;
   int                      req_gap_pct = 15;
   int                      rsp_stall_pct = 10;
   int                      idle_cycles = 0;

   msb_first_bit_field_reader u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_bit_count   (req_bit_count),
      .req_byte_addr   (req_byte_addr),
      .req_byte_value  (req_byte_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_field_value (rsp_field_value),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= REPORT_LINES) $display("MISMATCH: %s", what);
   endtask

   // Pulls n bits MSB-first from the cursor without moving it.
   function automatic logic [bfr_pkg::FIELD_W-1:0] gather_field(input int n);
      logic [bfr_pkg::ADDR_W-1:0]  p;
      logic [2:0]                  b;
      logic [bfr_pkg::FIELD_W-1:0] acc;
      p = cur_pos;
      b = cur_bit;
      acc = '0;
      for (int i = 0; i < n; i++) begin
         acc = {acc[bfr_pkg::FIELD_W-2:0], shadow_bytes[p][b]};
         if (b == 3'd0) begin
            b = 3'd7;
            p = p + 1'b1;
         end else begin
            b = b - 1'b1;
         end
      end
      return acc;
   endfunction

   function automatic void advance_cursor(input int n);
      int span;
      int step;
      int nb;
      span = 7 - int'(cur_bit) + n;
      step = span / 8;
      nb = 7 - span % 8;
      cur_pos = cur_pos + step[bfr_pkg::ADDR_W-1:0];
      cur_bit = nb[2:0];
      cur_left = cur_left - n[bfr_pkg::COUNT_W-1:0];
   endfunction

   function automatic field_beat_type predict_beat(input logic [2:0] act,
                                                   input logic [bfr_pkg::COUNT_W-1:0] cnt,
                                                   input logic [bfr_pkg::ADDR_W-1:0] addr,
                                                   input logic [7:0] val);
      field_beat_type r;
      r.seq = seq_no;
      r.ok = 1'b0;
      r.value = '0;
      case (act)
         bfr_pkg::ACT_WRITE: begin
            shadow_bytes[addr] = val;
            byte_written[addr] = 1'b1;
            r.ok = 1'b1;
         end
         bfr_pkg::ACT_READ, bfr_pkg::ACT_PEEK: begin
            if (cnt <= bfr_pkg::MAX_FIELD_BITS && cnt <= cur_left) begin
               r.value = gather_field(int'(cnt));
               r.ok = 1'b1;
               if (act == bfr_pkg::ACT_READ) advance_cursor(int'(cnt));
            end
         end
         bfr_pkg::ACT_SKIP: begin
            if (cnt <= cur_left) begin
               advance_cursor(int'(cnt));
               r.ok = 1'b1;
            end
         end
         bfr_pkg::ACT_REWIND: begin
            cur_pos = cfg_offset;
            cur_bit = cfg_bit;
            cur_left = cfg_total;
            r.ok = 1'b1;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_item(input int act, input int cnt, input int addr, input int val);
      int                          gap;
      logic [2:0]                  a;
      logic [bfr_pkg::COUNT_W-1:0] c;
      logic [bfr_pkg::ADDR_W-1:0]  ad;
      logic [7:0]                  v;
      a = act[2:0];
      c = cnt[bfr_pkg::COUNT_W-1:0];
      ad = addr[bfr_pkg::ADDR_W-1:0];
      v = val[7:0];
      if ($urandom_range(1, 100) <= req_gap_pct) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_action = a;
      req_bit_count = c;
      req_byte_addr = ad;
      req_byte_value = v;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_beats.push_back(predict_beat(a, c, ad, v));
      seq_no++;
   endtask

   // Lets every outstanding beat drain so the block is idle.
   task automatic await_quiet();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_access(input logic [1:0] idx, input bit wr,
                             input logic [bfr_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [bfr_pkg::CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      psel = 1'b1;
      pwrite = wr;
      penable = 1'b0;
      paddr = {idx, 2'b00};
      pwdata = wdata;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // Programs the three stream registers and reads each one back.
   task automatic set_stream(input int offset, input int sbit, input int total);
      logic [bfr_pkg::CSR_DATA_W-1:0] rd;
      logic [bfr_pkg::CSR_DATA_W-1:0] want [3];
      logic [1:0]                     regs [3];
      cfg_offset = offset[bfr_pkg::ADDR_W-1:0];
      cfg_bit = sbit[2:0];
      cfg_total = total[bfr_pkg::COUNT_W-1:0];
      regs[0] = bfr_pkg::REG_START_OFFSET;
      regs[1] = bfr_pkg::REG_START_BIT;
      regs[2] = bfr_pkg::REG_TOTAL_BITS;
      want[0] = bfr_pkg::CSR_DATA_W'(cfg_offset);
      want[1] = bfr_pkg::CSR_DATA_W'(cfg_bit);
      want[2] = bfr_pkg::CSR_DATA_W'(cfg_total);
      for (int i = 0; i < 3; i++) csr_access(regs[i], 1'b1, want[i], rd);
      for (int i = 0; i < 3; i++) begin
         csr_access(regs[i], 1'b0, '0, rd);
         if (rd !== want[i])
            report_mismatch($sformatf("register %0d reads %h, wrote %h", i, rd, want[i]));
      end
   endtask

   // Writes any byte that an n-bit field at the cursor covers and that was never written.
   task automatic fill_field_bytes(input int n);
      int                         nbytes;
      logic [bfr_pkg::ADDR_W-1:0] a;
      if (n > 0) begin
         nbytes = (7 - int'(cur_bit) + n - 1) / 8 + 1;
         for (int k = 0; k < nbytes; k++) begin
            a = cur_pos + k[bfr_pkg::ADDR_W-1:0];
            if (!byte_written[a])
               send_item(bfr_pkg::ACT_WRITE, $urandom_range(0, 32767), a,
                         $urandom_range(0, 255));
         end
      end
   endtask

   task automatic test_reset_state();
      send_item(bfr_pkg::ACT_READ, 0, 0, 0);
      send_item(bfr_pkg::ACT_PEEK, 1, 0, 0);
      send_item(bfr_pkg::ACT_SKIP, 1, 0, 0);
      send_item(bfr_pkg::ACT_SKIP, 0, 0, 0);
      for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
         send_item(a, 32767, 2047, 255);
      send_item(bfr_pkg::ACT_REWIND, 0, 0, 0);
   endtask

   // Stream starting at the LSB of the last bytes so a full field wraps the store.
   task automatic test_wrap_extremes();
      await_quiet();
      set_stream(2045, 0, 16384);
      send_item(bfr_pkg::ACT_WRITE, 0, 2045, 8'h00);
      send_item(bfr_pkg::ACT_WRITE, 0, 2046, 8'hFF);
      send_item(bfr_pkg::ACT_WRITE, 0, 2047, 8'hA5);
      send_item(bfr_pkg::ACT_WRITE, 0, 0, 8'h3C);
      send_item(bfr_pkg::ACT_WRITE, 0, 1, 8'h81);
      send_item(bfr_pkg::ACT_REWIND, 0, 0, 0);
      send_item(bfr_pkg::ACT_PEEK, 33, 0, 0);
      send_item(bfr_pkg::ACT_PEEK, 32, 0, 0);
      send_item(bfr_pkg::ACT_READ, 32, 0, 0);
      send_item(bfr_pkg::ACT_PEEK, 0, 0, 0);
      send_item(bfr_pkg::ACT_READ, 1, 0, 0);
      send_item(bfr_pkg::ACT_SKIP, 32767, 0, 0);
      send_item(bfr_pkg::ACT_SKIP, 16384, 0, 0);
      send_item(bfr_pkg::ACT_SKIP, int'(cur_left), 0, 0);
      send_item(bfr_pkg::ACT_READ, 0, 0, 0);
      send_item(bfr_pkg::ACT_READ, 1, 0, 0);
   endtask

   task automatic run_walk(input int target, input bit may_pause);
      int         done;
      int         r;
      int         n;
      int         pause_at;
      bit         paused;
      logic [2:0] act;
      done = 0;
      paused = !may_pause;
      pause_at = $urandom_range(target / 4, 3 * target / 4);
      send_item(bfr_pkg::ACT_REWIND, $urandom_range(0, 32767), $urandom_range(0, 2047),
                $urandom_range(0, 255));
      while (done < target) begin
         if (!paused && done >= pause_at) begin
            await_quiet();
            paused = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 60) begin
            act = (r < 40) ? bfr_pkg::ACT_READ : bfr_pkg::ACT_PEEK;
            n = $urandom_range(0, 9);
            if (n == 0) n = 0;
            else if (n == 1) n = 32;
            else n = $urandom_range(1, 31);
            if (n > int'(cur_left)) n = int'(cur_left);
            fill_field_bytes(n);
            send_item(act, n, $urandom_range(0, 2047), $urandom_range(0, 255));
         end else if (r < 70) begin
            if ($urandom_range(0, 3) == 0) n = $urandom_range(0, int'(cur_left));
            else n = $urandom_range(0, (cur_left < 40) ? int'(cur_left) : 40);
            send_item(bfr_pkg::ACT_SKIP, n, $urandom_range(0, 2047), $urandom_range(0, 255));
         end else if (r < 75) begin
            send_item(bfr_pkg::ACT_REWIND, $urandom_range(0, 32767), $urandom_range(0, 2047),
                      $urandom_range(0, 255));
         end else if (r < 80) begin
            send_item(bfr_pkg::ACT_WRITE, $urandom_range(0, 32767), $urandom_range(0, 2047),
                      $urandom_range(0, 255));
         end else if (r < 95) begin
            // Refused requests: too wide, or longer than what is left of the stream.
            if (r < 90) act = $urandom_range(0, 1) ? bfr_pkg::ACT_READ : bfr_pkg::ACT_PEEK;
            else act = bfr_pkg::ACT_SKIP;
            if (act != bfr_pkg::ACT_SKIP && $urandom_range(0, 1)) n = $urandom_range(33, 32767);
            else n = $urandom_range(int'(cur_left) + 1, int'(cur_left) + 40);
            send_item(act, n, $urandom_range(0, 2047), $urandom_range(0, 255));
         end else begin
            act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
            send_item(act, $urandom_range(0, 32767), $urandom_range(0, 2047),
                      $urandom_range(0, 255));
            continue;
         end
         done++;
      end
   endtask

   task automatic test_random_streams();
      int offset;
      int sbit;
      int total;
      for (int ph = 0; ph < 7; ph++) begin
         await_quiet();
         case (ph)
            0: begin offset = 0; sbit = 7; total = 16384; end
            1: begin offset = 2047; sbit = 0; total = 16384; end
            2: begin offset = 0; sbit = 0; total = 0; end
            default: begin
               offset = $urandom_range(0, 2047);
               sbit = $urandom_range(0, 7);
               total = (ph % 2) ? $urandom_range(0, 400) : $urandom_range(0, 16384);
            end
         endcase
         if (ph == 3) begin
            req_gap_pct = 0;
            rsp_stall_pct = 0;
         end else begin
            req_gap_pct = $urandom_range(5, 30);
            rsp_stall_pct = $urandom_range(5, 30);
         end
         set_stream(offset, sbit, total);
         run_walk((ph == 2) ? 80 : 200, 1'b1);
      end
   endtask

   task automatic test_steady_finish();
      await_quiet();
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      set_stream($urandom_range(0, 2047), $urandom_range(0, 7), $urandom_range(0, 16384));
      run_walk(170, 1'b0);
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready = 1'b0;
         end else if ($urandom_range(1, 100) <= rsp_stall_pct) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected: ok %b value %h",
                                      rsp_ok, rsp_field_value));
         end else begin
            head = expected_beats.pop_front();
            if (rsp_ok !== head.ok)
               report_mismatch($sformatf("item %0d: ok %b, expected %b",
                                         head.seq, rsp_ok, head.ok));
            if (rsp_field_value !== head.value)
               report_mismatch($sformatf("item %0d: field_value %h, expected %h",
                                         head.seq, rsp_field_value, head.value));
         end
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("** msb_first_bit_field_reader: FAILED **");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = bfr_pkg::ACT_WRITE;
      req_bit_count = '0;
      req_byte_addr = '0;
      req_byte_value = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_state();
      test_wrap_extremes();
      test_random_streams();
      test_steady_finish();
      await_quiet();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("** msb_first_bit_field_reader: PASSED **");
      end else begin
         $display("** msb_first_bit_field_reader: FAILED **");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/bfr_pkg.sv
rtl/core/bfr_store.sv
rtl/core/bfr_cursor.sv
rtl/core/bfr_fetch.sv
rtl/core/msb_first_bit_field_reader.sv
test/msb_first_bit_field_reader_tb.sv
